// ----- sv/least_loaded_job_assigner_assert.svh -----
// Assertion macros shared by the job assigner modules.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef LEAST_LOADED_JOB_ASSIGNER_ASSERT_SVH
`define LEAST_LOADED_JOB_ASSIGNER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LLJA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LLJA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/llja_pkg.sv -----
`default_nettype none

package llja_pkg;

  // Field widths
  localparam int LOAD_W    = 32;
  localparam int DUR_W     = 16;
  localparam int IDX_OUT_W = 4;
  localparam int CFG_W     = 5;

  // Machine count after reset
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd4;

  // Saturation value of a machine load
  localparam logic [LOAD_W-1:0] LOAD_MAX = 32'hFFFF_FFFF;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_job;  // capture the accepted transaction, restart the scan
    logic scan;      // read the next machine load
    logic commit;    // add the job, write back, present the result
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_last;  // the read issued this cycle is the last active machine
    logic out_free;   // the result register can take a new result
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- sv/least_loaded_job_assigner.sv -----
// Greedy list scheduler: each input transaction carries one job duration and
// a last-job flag; the job goes to the least-loaded active machine (lowest
// index on ties) and one result transaction returns the machine, its new
// load, the batch makespan, a saturation flag and the batch-done flag.
// Both channels use valid/stall; a transaction moves on a clock edge with
// valid high and stall low. cfg_wr_en/cfg_wr_data set the active machine
// count (0 acts as 1, values above MAX_MACHINES act as MAX_MACHINES); write
// it only while no job is in flight.
// The loads sit in a single-port-read RAM; the scan reads one load a cycle
// over the N active machines, then a drain state waits for the last read
// before the update state commits the result.
// in_stall is high from the accept edge until the result is committed.
// The result sits in an output register, so the next job is accepted while
// it waits; a stalled result holds the commit of the following job.
// Reset clears all loads, the makespan and the result valid flag and sets the
// machine count to 4; loads and makespan also clear after a last job.
`default_nettype none

module least_loaded_job_assigner #(
  parameter int MAX_MACHINES = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [llja_pkg::CFG_W-1:0]    cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [llja_pkg::DUR_W-1:0]    in_job_duration,
  input  wire logic                          in_last_job,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [llja_pkg::IDX_OUT_W-1:0]     out_machine_index,
  output logic [llja_pkg::LOAD_W-1:0]        out_machine_load,
  output logic [llja_pkg::LOAD_W-1:0]        out_makespan,
  output logic                               out_load_saturated,
  output logic                               out_batch_done
);

  llja_pkg::dp_cmd_t  cmd;
  llja_pkg::dp_stat_t stat;

  llja_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  llja_datapath #(
    .MAX_MACHINES (MAX_MACHINES)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_job_duration    (in_job_duration),
    .in_last_job        (in_last_job),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_machine_index  (out_machine_index),
    .out_machine_load   (out_machine_load),
    .out_makespan       (out_makespan),
    .out_load_saturated (out_load_saturated),
    .out_batch_done     (out_batch_done)
  );

endmodule

`default_nettype wire

// ----- sv/llja_ram.sv -----
`default_nettype none

module llja_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/llja_datapath.sv -----
`default_nettype none

`include "least_loaded_job_assigner_assert.svh"

module llja_datapath #(
  parameter int MAX_MACHINES = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [llja_pkg::CFG_W-1:0]      cfg_wr_data,
  input  wire logic [llja_pkg::DUR_W-1:0]      in_job_duration,
  input  wire logic                            in_last_job,
  input  wire llja_pkg::dp_cmd_t               cmd,
  output llja_pkg::dp_stat_t                   stat,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [llja_pkg::IDX_OUT_W-1:0]       out_machine_index,
  output logic [llja_pkg::LOAD_W-1:0]          out_machine_load,
  output logic [llja_pkg::LOAD_W-1:0]          out_makespan,
  output logic                                 out_load_saturated,
  output logic                                 out_batch_done
);

  localparam int IDX_W = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int CNT_W = $clog2(MAX_MACHINES + 1);
  localparam int CMP_W = (CNT_W > llja_pkg::CFG_W) ? CNT_W : llja_pkg::CFG_W;
  localparam logic [CMP_W-1:0] MAX_CNT = CMP_W'(MAX_MACHINES);
  localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_MACHINES - 1);

  // Configuration and batch state
  logic [llja_pkg::CFG_W-1:0]  machines_in_use_r;
  logic [MAX_MACHINES-1:0]     valid_r;
  logic [llja_pkg::LOAD_W-1:0] max_r;

  // Job and scan state
  logic [llja_pkg::DUR_W-1:0]  job_dur_r;
  logic                        last_r;
  logic [IDX_W-1:0]            scan_idx_r;
  logic                        rd_vld_r;
  logic [IDX_W-1:0]            rd_idx_r;
  logic [IDX_W-1:0]            best_idx_r;
  logic [llja_pkg::LOAD_W-1:0] best_load_r;

  // Result register
  logic                          out_valid_r;
  logic [llja_pkg::IDX_OUT_W-1:0] out_machine_index_r;
  logic [llja_pkg::LOAD_W-1:0]   out_machine_load_r;
  logic [llja_pkg::LOAD_W-1:0]   out_makespan_r;
  logic                          out_load_saturated_r;
  logic                          out_batch_done_r;

  logic [CMP_W-1:0]            cfg_ext;
  logic [IDX_W-1:0]            last_idx;
  logic [llja_pkg::LOAD_W-1:0] rd_data;
  logic [llja_pkg::LOAD_W-1:0] cur_load;
  logic [llja_pkg::LOAD_W:0]   sum;
  logic                        sat;
  logic [llja_pkg::LOAD_W-1:0] new_load;
  logic [llja_pkg::LOAD_W-1:0] new_max;

  // Clamp the machine count to 1..MAX_MACHINES and take its last index
  always_comb begin
    cfg_ext = CMP_W'(machines_in_use_r);
    if (cfg_ext == '0) begin
      last_idx = '0;
    end else if (cfg_ext >= MAX_CNT) begin
      last_idx = MAX_IDX;
    end else begin
      last_idx = IDX_W'(cfg_ext - CMP_W'(1));
    end
  end

  assign stat.scan_last = (scan_idx_r == last_idx);
  assign stat.out_free  = !out_valid_r || !out_stall;

  // Machine load store
  llja_ram #(
    .WIDTH (llja_pkg::LOAD_W),
    .DEPTH (MAX_MACHINES)
  ) u_loads (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (best_idx_r),
    .wdata (new_load),
    .re    (cmd.scan),
    .raddr (scan_idx_r),
    .rdata (rd_data)
  );

  // A load not written since the batch began reads as zero
  assign cur_load = valid_r[rd_idx_r] ? rd_data : '0;

  // Add the job with saturation and track the batch maximum
  always_comb begin
    sum      = {1'b0, best_load_r} + (llja_pkg::LOAD_W + 1)'(job_dur_r);
    sat      = sum[llja_pkg::LOAD_W];
    new_load = sat ? llja_pkg::LOAD_MAX : sum[llja_pkg::LOAD_W-1:0];
    new_max  = (new_load > max_r) ? new_load : max_r;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      machines_in_use_r <= llja_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      machines_in_use_r <= cfg_wr_data;
    end
  end

  // Capture the job and advance the scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan;
      if (cmd.load_job) begin
        scan_idx_r <= '0;
      end else if (cmd.scan) begin
        scan_idx_r <= scan_idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_job) begin
      job_dur_r <= in_job_duration;
      last_r    <= in_last_job;
    end
    if (cmd.scan) begin
      rd_idx_r <= scan_idx_r;
    end
  end

  // Keep the least load seen, lowest index on ties
  always_ff @(posedge clk) begin
    if (rd_vld_r && ((rd_idx_r == '0) || (cur_load < best_load_r))) begin
      best_idx_r  <= rd_idx_r;
      best_load_r <= cur_load;
    end
  end

  // Batch state: mark written loads, clear everything after the last job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      max_r   <= '0;
    end else if (cmd.commit) begin
      if (last_r) begin
        valid_r <= '0;
        max_r   <= '0;
      end else begin
        valid_r[best_idx_r] <= 1'b1;
        max_r               <= new_max;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_machine_index_r  <= llja_pkg::IDX_OUT_W'(best_idx_r);
      out_machine_load_r   <= new_load;
      out_makespan_r       <= new_max;
      out_load_saturated_r <= sat;
      out_batch_done_r     <= last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_machine_index  = out_machine_index_r;
  assign out_machine_load   = out_machine_load_r;
  assign out_makespan       = out_makespan_r;
  assign out_load_saturated = out_load_saturated_r;
  assign out_batch_done     = out_batch_done_r;

  `LLJA_ASSERT_NEXT(a_commit_shows_result, cmd.commit, out_valid_r,
    "commit did not load the result register")
  `LLJA_ASSERT_NEXT(a_last_clears_batch, cmd.commit && last_r,
    (valid_r == '0) && (max_r == '0), "batch state not cleared after last job")
  `LLJA_ASSERT_NEXT(a_max_covers_load, cmd.commit && !last_r,
    max_r >= out_machine_load_r, "makespan below the load just assigned")

endmodule

`default_nettype wire

// ----- sv/llja_ctrl.sv -----
`default_nettype none

`include "least_loaded_job_assigner_assert.svh"

module llja_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output llja_pkg::dp_cmd_t       cmd,
  input  wire llja_pkg::dp_stat_t stat
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_UPDATE = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Sequence one job: scan all active loads, drain the read, then commit
  always_comb begin
    state_nxt    = state_r;
    cmd.load_job = 1'b0;
    cmd.scan     = 1'b0;
    cmd.commit   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load_job = 1'b1;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `LLJA_ASSERT_NEXT(a_accept_starts_scan, accept, state_r == ST_SCAN,
    "accepted transaction did not start a scan")
  `LLJA_ASSERT_NEXT(a_scan_end_drains, (state_r == ST_SCAN) && stat.scan_last,
    state_r == ST_DRAIN, "scan did not stop at the last active machine")
  `LLJA_ASSERT_NEXT(a_commit_returns_idle, cmd.commit, state_r == ST_IDLE && !in_stall,
    "controller not ready after commit")

endmodule

`default_nettype wire

// ----- verif/assignment_check_pkg.sv -----
`timescale 1ns / 100ps

package assignment_check_pkg;
  import llja_pkg::*;

  // Load slots kept by the block (its default MAX_MACHINES)
  localparam int MACHINE_SLOTS = 16;

  // One result transaction
  typedef struct packed {
    logic [IDX_OUT_W-1:0] machine;
    logic [LOAD_W-1:0]    load;
    logic [LOAD_W-1:0]    span;
    logic                 saturated;
    logic                 done;
  } assignment_t;

  class assignment_checker;
    logic [LOAD_W-1:0] loads [MACHINE_SLOTS];
    logic [LOAD_W-1:0] span;
    logic [CFG_W-1:0]  count;
    assignment_t       expected_assignments [$];
    int                error_count;

    function new();
      clear_loads();
      count = CFG_RESET;
      error_count = 0;
    endfunction

    // Drop all loads and the makespan at the end of a batch
    function void clear_loads();
      foreach (loads[k]) loads[k] = '0;
      span = '0;
    endfunction

    function void set_count(logic [CFG_W-1:0] value);
      count = value;
    endfunction

    function int pending();
      return expected_assignments.size();
    endfunction

    // Place one accepted job on the least-loaded active machine
    function void predict_assignment(logic [DUR_W-1:0] duration, logic last);
      int unsigned active;
      int unsigned best;
      logic [LOAD_W:0] sum;
      assignment_t a;
      // count 0 acts as one machine, anything above the slots as all slots
      if (count == 0)
        active = 1;
      else if (count > MACHINE_SLOTS)
        active = MACHINE_SLOTS;
      else
        active = count;
      best = 0;
      for (int k = 1; k < active; k++) begin
        if (loads[k] < loads[best]) best = k;
      end
      // clamp the new load at the top value
      sum = {1'b0, loads[best]} + duration;
      a.saturated = sum[LOAD_W];
      a.load = a.saturated ? LOAD_MAX : sum[LOAD_W-1:0];
      loads[best] = a.load;
      if (a.load > span) span = a.load;
      a.machine = IDX_OUT_W'(best);
      a.span = span;
      a.done = last;
      expected_assignments = {expected_assignments, a};
      if (last) clear_loads();
    endfunction

    task report_mismatch(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
    endtask

    // Compare one result transaction with the oldest expectation
    task check_assignment(assignment_t got);
      assignment_t want;
      if (expected_assignments.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: machine %0d load %0h",
                                  got.machine, got.load));
        return;
      end
      want = expected_assignments.pop_front();
      if (got.machine !== want.machine)
        report_mismatch($sformatf("machine_index got %0d want %0d",
                                  got.machine, want.machine));
      if (got.load !== want.load)
        report_mismatch($sformatf("machine_load got %0h want %0h", got.load, want.load));
      if (got.span !== want.span)
        report_mismatch($sformatf("makespan got %0h want %0h", got.span, want.span));
      if (got.saturated !== want.saturated)
        report_mismatch($sformatf("load_saturated got %0b want %0b",
                                  got.saturated, want.saturated));
      if (got.done !== want.done)
        report_mismatch($sformatf("batch_done got %0b want %0b", got.done, want.done));
    endtask
  endclass

endpackage

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import llja_pkg::*;
  import assignment_check_pkg::*;

  localparam int SETTLE_CYCLES   = 24;
  localparam int PRESSURE_CYCLES = 200;
  localparam int RANDOM_JOBS     = 480;
  localparam int STACK_JOBS      = 6;
  localparam int CYCLE_LIMIT     = 3000000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]     cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [DUR_W-1:0]     in_job_duration = '0;
  logic                 in_last_job = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [IDX_OUT_W-1:0] out_machine_index;
  logic [LOAD_W-1:0]    out_machine_load;
  logic [LOAD_W-1:0]    out_makespan;
  logic                 out_load_saturated;
  logic                 out_batch_done;

  assignment_checker sb;
  bit tx_gaps_on = 1'b1;
  bit rx_gaps_on = 1'b1;
  bit pressure_req = 1'b0;
  int unsigned cycles = 0;

  least_loaded_job_assigner uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_job_duration    (in_job_duration),
    .in_last_job        (in_last_job),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_machine_index  (out_machine_index),
    .out_machine_load   (out_machine_load),
    .out_makespan       (out_makespan),
    .out_load_saturated (out_load_saturated),
    .out_batch_done     (out_batch_done)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int idle_length();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(20, 50);
    return $urandom_range(1, 3);
  endfunction

  // Favor ties and the extremes
  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return DUR_W'($urandom_range(0, 3));
      default: return DUR_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_count();
    case ($urandom_range(0, 7))
      0:       return 5'd0;
      1:       return 5'd1;
      2:       return 5'd16;
      3:       return 5'd31;
      4:       return CFG_W'($urandom_range(17, 31));
      default: return CFG_W'($urandom_range(1, 16));
    endcase
  endfunction

  // Watch both channels
  always @(posedge clk) begin : monitor
    assignment_t got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.machine   = out_machine_index;
        got.load      = out_machine_load;
        got.span      = out_makespan;
        got.saturated = out_load_saturated;
        got.done      = out_batch_done;
        sb.check_assignment(got);
      end
      if (in_valid && !in_stall)
        sb.predict_assignment(in_job_duration, in_last_job);
    end
  end

  // Result side: random holds, plus one long hold on request
  initial begin : receiver
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (pressure_req) begin
        pressure_req = 1'b0;
        hold = PRESSURE_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
        hold = idle_length() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Present one job and wait until it is taken; valid stays high on return
  task automatic send_job(input logic [DUR_W-1:0] duration, input logic last);
    in_valid <= 1'b1;
    in_job_duration <= duration;
    in_last_job <= last;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  task automatic pause_input(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic offer(input logic [DUR_W-1:0] duration, input logic last);
    send_job(duration, last);
    if (tx_gaps_on && $urandom_range(0, 2) == 0)
      pause_input(idle_length());
  endtask

  // Drain the block, then write the machine count
  task automatic write_count(input logic [CFG_W-1:0] value);
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_count(value);
  endtask

  initial begin : main
    int sent;
    int batch;
    int split;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset count of four: extremes, ties, end of batch
    offer(16'h0000, 1'b0);
    offer(16'hFFFF, 1'b0);
    offer(16'h0001, 1'b0);
    offer(16'h0001, 1'b0);
    offer(16'h0000, 1'b0);
    offer(16'h8000, 1'b0);
    offer(16'h7FFF, 1'b1);

    // Count zero acts as one machine
    write_count(5'd0);
    offer(16'h0005, 1'b0);
    offer(16'h0007, 1'b1);

    // Count above the slot total acts as all slots
    write_count(5'd31);
    offer(16'h5555, 1'b0);
    offer(16'hAAAA, 1'b1);

    // Lower the count within a batch; idle loads stay until the batch ends
    write_count(5'd16);
    offer(16'h0003, 1'b0);
    offer(16'h0001, 1'b0);
    offer(16'h0002, 1'b0);
    offer(16'h0000, 1'b0);
    offer(16'hFFFF, 1'b0);
    offer(16'h0004, 1'b0);
    write_count(5'd3);
    offer(16'h0010, 1'b0);
    offer(16'h0020, 1'b0);
    offer(16'h0030, 1'b1);

    // Stack jobs on one machine, then widen the search
    write_count(5'd1);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    repeat (STACK_JOBS) send_job(16'hFFFF, 1'b0);
    write_count(5'd2);
    offer(16'h0010, 1'b0);
    offer(16'hFFFF, 1'b0);
    offer(16'h0000, 1'b1);

    // Hold off the result side while jobs keep coming
    write_count(5'd4);
    rx_gaps_on = 1'b1;
    pressure_req = 1'b1;
    repeat (8) send_job(pick_duration(), 1'b0);
    sent = 8;

    // Random batches with occasional count changes
    tx_gaps_on = 1'b1;
    while (sent < RANDOM_JOBS) begin
      if ($urandom_range(0, 2) == 0) write_count(pick_count());
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      batch = $urandom_range(1, 40);
      split = ($urandom_range(0, 5) == 0) ? $urandom_range(1, batch) : 0;
      for (int j = 1; j <= batch; j++) begin
        if (j == split) write_count(pick_count());
        offer(pick_duration(), j == batch);
      end
      sent += batch;
    end

    // Drain and settle
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/llja_pkg.sv
sv/llja_ram.sv
sv/llja_datapath.sv
sv/llja_ctrl.sv
sv/least_loaded_job_assigner.sv
verif/assignment_check_pkg.sv
verif/tb.sv
